// File: hw/rtl/aes256_cbc_encrypt_macros.svh
// Assertion macros shared by the AES-256 CBC encryption RTL.
// Defining ASSERT_OFF turns every check into an empty statement.
`ifndef AES256_CBC_ENCRYPT_MACROS_SVH
`define AES256_CBC_ENCRYPT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c, msg)
`define ASSERT_NEXT(label, clk, rst_n, a, c, msg)
`endif
`endif

// File: hw/rtl/aes_pkg.sv
// Shared types, constants and byte functions for the AES-256 CBC encryptor.
// No dependencies.
package aes_pkg;
    localparam int BLOCK_W = 128;
    localparam int WORD_W = 64;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_ROUNDS = 14;
    localparam int RND_W = 4;
    localparam int NUM_RKEYS = 15;
    localparam int KEY_STEPS = 7;

    localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IV_LO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IV_HI = 3'd5;

    // Datapath commands issued by the controller.
    typedef struct packed {
        logic key_start;
        logic key_step;
        logic [2:0] key_idx;
        logic load;
        logic round;
        logic final_rnd;
        logic [RND_W-1:0] rnd;
        logic finish;
    } aes_cmd_t;

    typedef logic [7:0] sbox_t [256];
    localparam sbox_t SBOX = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // Multiply by x in GF(2^8).
    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of a block sits in bits 8*i+7 : 8*i.
    function automatic logic [BLOCK_W-1:0] sub_shift(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] o;
        o = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                o[8*(4*c+r) +: 8] = SBOX[s[8*(4*((c+r)%4)+r) +: 8]];
            end
        end
        return o;
    endfunction

    function automatic logic [BLOCK_W-1:0] mix_columns(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] o;
        logic [7:0] a0, a1, a2, a3;
        o = '0;
        for (int c = 0; c < 4; c++)
        begin
            a0 = s[8*(4*c) +: 8];
            a1 = s[8*(4*c+1) +: 8];
            a2 = s[8*(4*c+2) +: 8];
            a3 = s[8*(4*c+3) +: 8];
            o[8*(4*c) +: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            o[8*(4*c+1) +: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            o[8*(4*c+2) +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            o[8*(4*c+3) +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        return o;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // Round constants 0x01 .. 0x40 indexed by key schedule step.
    function automatic logic [7:0] rcon(input logic [2:0] i);
        logic [7:0] v;
        case (i)
            3'd0: v = 8'h01;
            3'd1: v = 8'h02;
            3'd2: v = 8'h04;
            3'd3: v = 8'h08;
            3'd4: v = 8'h10;
            3'd5: v = 8'h20;
            3'd6: v = 8'h40;
            default: v = 8'h00;
        endcase
        return v;
    endfunction
endpackage

// File: hw/rtl/aes_ram.sv
// Generic single-port-write RAM with one registered read port.
// No dependencies.
module aes_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// File: hw/rtl/aes_ctrl.sv
// Controller for the AES-256 CBC encryptor: key schedule sequencing,
// round sequencing and the output handshake. Depends on aes_pkg.
`include "aes256_cbc_encrypt_macros.svh"
module aes_ctrl
    import aes_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      key_dirty,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output aes_cmd_t  cmd
);
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_KEY   = 5'b00010,
        ST_WHITE = 5'b00100,
        ST_ROUND = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [RND_W-1:0] cnt_reg, cnt_next;
    logic out_valid_reg, out_valid_next;

    // A new block may start when idle, the key is current and the output is free
    // or being emptied this cycle.
    assign in_ready = (state_reg == ST_IDLE) && !key_dirty && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd = '0;
        cmd.key_idx = cnt_reg[3:1];
        cmd.rnd = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (key_dirty)
                begin
                    cmd.key_start = 1'b1;
                    cnt_next = '0;
                    state_next = ST_KEY;
                end
                else if (in_valid && in_ready)
                begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    state_next = ST_WHITE;
                end
            end
            ST_KEY:
            begin
                // Key steps issue on even counts with the low key write; the high key
                // is written on each odd count.
                cmd.key_step = !cnt_reg[0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == RND_W'(2 * KEY_STEPS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_WHITE:
            begin
                // RAM read of round key 1 is issued here.
                cnt_next = RND_W'(1);
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
                cmd.final_rnd = (cnt_reg == RND_W'(NUM_ROUNDS));
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == RND_W'(NUM_ROUNDS))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                cmd.finish = 1'b1;
                out_valid_next = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ASSERT_IMPLIES(a_one_hot, clk, rst_n, 1'b1, $onehot(state_reg), "state not one-hot")
    `ASSERT_IMPLIES(a_done_free, clk, rst_n, state_reg == ST_DONE, !out_valid_reg, "result lost")
    `ASSERT_NEXT(a_load_white, clk, rst_n, cmd.load, state_reg == ST_WHITE, "no whitening")
    `ASSERT_IMPLIES(a_no_key_busy, clk, rst_n, in_ready, state_reg == ST_IDLE && !key_dirty, "busy")
endmodule

// File: hw/rtl/aes_dp.sv
// Datapath of the AES-256 CBC encryptor: config registers, key expansion,
// round-key RAM, state register and chaining value. Depends on aes_pkg, aes_ram.
module aes_dp
    import aes_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [WORD_W-1:0]    cfg_data,
    input  aes_cmd_t             cmd,
    input  logic [WORD_W-1:0]    plain_low,
    input  logic [WORD_W-1:0]    plain_high,
    input  logic                 block_last,
    output logic                 key_dirty,
    output logic [WORD_W-1:0]    cipher_low,
    output logic [WORD_W-1:0]    cipher_high,
    output logic                 result_last
);
    logic [4*WORD_W-1:0] key_reg;
    logic [2*WORD_W-1:0] iv_reg;
    logic [BLOCK_W-1:0] chain_reg;
    logic key_dirty_reg;
    logic key_wr;
    logic [BLOCK_W-1:0] kw_reg, kw_next;
    logic [BLOCK_W-1:0] kw_prev_reg;
    logic [BLOCK_W-1:0] st_reg, st_next;
    logic [BLOCK_W-1:0] res_reg;
    logic last_reg, res_last_reg;
    logic [BLOCK_W-1:0] rk0_reg;
    logic ram_we;
    logic [RND_W-1:0] ram_waddr, ram_raddr;
    logic [BLOCK_W-1:0] ram_wdata, ram_rdata;
    logic [BLOCK_W-1:0] new_lo, new_hi;
    logic [31:0] t0, t4;

    assign key_wr = cfg_we && (cfg_idx <= REG_KEY3);

    // Configuration registers; a key write marks the schedule stale.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
            iv_reg <= '0;
            chain_reg <= '0;
            key_dirty_reg <= 1'b1;
        end
        else
        begin
            key_dirty_reg <= key_wr || (key_dirty_reg && !cmd.key_start);
            if (key_wr)
            begin
                key_reg[WORD_W*cfg_idx[1:0] +: WORD_W] <= cfg_data;
            end
            if (cfg_we && cfg_idx == REG_IV_LO)
            begin
                iv_reg[WORD_W-1:0] <= cfg_data;
                chain_reg <= {iv_reg[2*WORD_W-1:WORD_W], cfg_data};
            end
            else if (cfg_we && cfg_idx == REG_IV_HI)
            begin
                iv_reg[2*WORD_W-1:WORD_W] <= cfg_data;
                chain_reg <= {cfg_data, iv_reg[WORD_W-1:0]};
            end
            else if (cmd.finish)
            begin
                chain_reg <= st_reg;
            end
        end
    end
    assign key_dirty = key_dirty_reg;

    // One key schedule step makes two round keys from the previous two.
    always_comb
    begin
        t0 = sub_word({kw_reg[103:96], kw_reg[127:104]})
            ^ {24'h0, rcon(cmd.key_idx)};
        new_lo[31:0] = kw_prev_reg[31:0] ^ t0;
        new_lo[63:32] = kw_prev_reg[63:32] ^ new_lo[31:0];
        new_lo[95:64] = kw_prev_reg[95:64] ^ new_lo[63:32];
        new_lo[127:96] = kw_prev_reg[127:96] ^ new_lo[95:64];
        t4 = sub_word(new_lo[127:96]);
        new_hi[31:0] = kw_reg[31:0] ^ t4;
        new_hi[63:32] = kw_reg[63:32] ^ new_hi[31:0];
        new_hi[95:64] = kw_reg[95:64] ^ new_hi[63:32];
        new_hi[127:96] = kw_reg[127:96] ^ new_hi[95:64];
        kw_next = new_hi;
    end

    // Round keys 1..14 go to RAM: key 1 at start, then two per step
    // (the last step writes key 14 and a spare slot 15).
    always_comb
    begin
        ram_we = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        if (cmd.key_start)
        begin
            ram_we = 1'b1;
            ram_waddr = RND_W'(1);
            ram_wdata = key_reg[4*WORD_W-1:2*WORD_W];
        end
        else if (cmd.key_step)
        begin
            ram_we = 1'b1;
            ram_waddr = {cmd.key_idx, 1'b0} + RND_W'(2);
            ram_wdata = new_lo;
        end
    end

    // The second key of each step lands through a shadow write;
    // the RAM takes one write per cycle, so the high key is held in kw_reg and
    // written in the cycle that follows each step.
    logic hi_pend_reg;
    logic [RND_W-1:0] hi_addr_reg;
    logic wr2_en;
    logic [RND_W-1:0] wr2_addr;
    logic [BLOCK_W-1:0] wr2_data;

    always_comb
    begin
        wr2_en = ram_we;
        wr2_addr = ram_waddr;
        wr2_data = ram_wdata;
        if (hi_pend_reg && !cmd.key_step && !cmd.key_start)
        begin
            wr2_en = 1'b1;
            wr2_addr = hi_addr_reg;
            wr2_data = kw_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.key_start)
        begin
            kw_prev_reg <= key_reg[2*WORD_W-1:0];
            kw_reg <= key_reg[4*WORD_W-1:2*WORD_W];
            rk0_reg <= key_reg[2*WORD_W-1:0];
        end
        else if (cmd.key_step)
        begin
            kw_prev_reg <= new_lo;
            kw_reg <= kw_next;
        end
        hi_addr_reg <= {cmd.key_idx, 1'b0} + RND_W'(3);
    end

    // High-key write pending flag, cleared once the write goes out.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_pend_reg <= 1'b0;
        end
        else
        begin
            hi_pend_reg <= cmd.key_step;
        end
    end

    // Round-key memory. Reads for round r+1 issue during round r.
    assign ram_raddr = cmd.round ? (cmd.rnd + 1'b1) : RND_W'(1);

    aes_ram #(.WIDTH(BLOCK_W), .DEPTH(16)) u_rk_ram (
        .clk     (clk),
        .wr_en   (wr2_en),
        .wr_addr (wr2_addr),
        .wr_data (wr2_data),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // State update: load with whitening, then one round per cycle.
    always_comb
    begin
        st_next = st_reg;
        if (cmd.load)
        begin
            st_next = ({plain_high, plain_low} ^ chain_reg) ^ rk0_reg;
        end
        else if (cmd.round)
        begin
            if (cmd.final_rnd)
            begin
                st_next = sub_shift(st_reg) ^ ram_rdata;
            end
            else
            begin
                st_next = mix_columns(sub_shift(st_reg)) ^ ram_rdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
        if (cmd.load)
        begin
            last_reg <= block_last;
        end
        if (cmd.finish)
        begin
            res_reg <= st_reg;
            res_last_reg <= last_reg;
        end
    end

    assign cipher_low = res_reg[WORD_W-1:0];
    assign cipher_high = res_reg[2*WORD_W-1:WORD_W];
    assign result_last = res_last_reg;
endmodule

// File: hw/rtl/aes256_cbc_encrypt.sv
// Channel | Signals                                  | Direction
// in      | in_valid/in_ready, plain_low/high, last  | into block
// out     | out_valid/out_ready, cipher_low/high, last| out of block
// cfg     | cfg_we, cfg_idx, cfg_data                | into block
// A block passes through the load, a round-key memory read, 14 rounds in one shared
// round unit and a result step; the next block is taken only after the result step.
// After reset and after any key write the key schedule runs before a block is taken.
// The input stalls while a finished block waits unaccepted in the result register.
// Top level of the AES-256 CBC encryptor. Depends on aes_pkg, aes_ctrl, aes_dp.
module aes256_cbc_encrypt
    import aes_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [WORD_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [WORD_W-1:0]    plain_low,
    input  logic [WORD_W-1:0]    plain_high,
    input  logic                 block_last,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [WORD_W-1:0]    cipher_low,
    output logic [WORD_W-1:0]    cipher_high,
    output logic                 result_last
);
    aes_cmd_t cmd;
    logic key_dirty;

    aes_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_dirty (key_dirty),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    aes_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_idx     (cfg_idx),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .plain_low   (plain_low),
        .plain_high  (plain_high),
        .block_last  (block_last),
        .key_dirty   (key_dirty),
        .cipher_low  (cipher_low),
        .cipher_high (cipher_high),
        .result_last (result_last)
    );
endmodule

// File: tb/sv/aes256_cbc_checker.sv
// Checker for the AES-256 CBC encryptor: watches config writes and both channels,
// predicts each ciphertext with its own AES-256 model and compares in order.
// Depends on aes_pkg for widths and register indexes only.
`timescale 1ns / 1ps

module aes256_cbc_checker
    import aes_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [WORD_W-1:0]    cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [WORD_W-1:0]    plain_low,
    input  logic [WORD_W-1:0]    plain_high,
    input  logic                 block_last,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [WORD_W-1:0]    cipher_low,
    input  logic [WORD_W-1:0]    cipher_high,
    input  logic                 result_last,
    output int                   fail_count,
    output int                   pending_count,
    output int                   result_count
);

    typedef struct {
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        logic              last;
    } cipher_t;

    logic [WORD_W-1:0]  key_word [4];
    logic [WORD_W-1:0]  iv_word [2];
    logic [BLOCK_W-1:0] chain;
    logic [BLOCK_W-1:0] sched [15];
    cipher_t            expected_q [$];

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    // S-box built from the field inverse and the affine map.
    function automatic logic [7:0] sbyte(input logic [7:0] x);
        logic [7:0] r;
        logic [7:0] b;
        r = 8'h01;
        b = x;
        for (int e = 0; e < 8; e++)
        begin
            if (e != 0)
                r = gmul(r, b);
            b = gmul(b, b);
        end
        return r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]}
               ^ {r[3:0], r[7:4]} ^ 8'h63;
    endfunction

    // Expands the 256-bit key into 15 round keys, bytes little endian.
    task automatic expand_schedule();
        logic [7:0] w [240];
        logic [7:0] t [4];
        logic [7:0] rc;
        logic [7:0] f;
        rc = 8'h01;
        for (int i = 0; i < 32; i++)
            w[i] = key_word[i / 8][8*(i % 8) +: 8];
        for (int i = 8; i < 60; i++)
        begin
            for (int j = 0; j < 4; j++)
                t[j] = w[4*(i-1)+j];
            if (i % 8 == 0)
            begin
                f = t[0];
                t[0] = sbyte(t[1]) ^ rc;
                t[1] = sbyte(t[2]);
                t[2] = sbyte(t[3]);
                t[3] = sbyte(f);
                rc = gmul(rc, 8'h02);
            end
            else if (i % 8 == 4)
            begin
                for (int j = 0; j < 4; j++)
                    t[j] = sbyte(t[j]);
            end
            for (int j = 0; j < 4; j++)
                w[4*i+j] = w[4*(i-8)+j] ^ t[j];
        end
        for (int r = 0; r < 15; r++)
            for (int i = 0; i < 16; i++)
                sched[r][8*i +: 8] = w[16*r+i];
    endtask

    function automatic logic [BLOCK_W-1:0] encrypt_block(input logic [BLOCK_W-1:0] pt);
        logic [BLOCK_W-1:0] s;
        logic [BLOCK_W-1:0] o;
        logic [7:0] a0, a1, a2, a3;
        s = pt ^ sched[0];
        for (int rnd = 1; rnd <= 14; rnd++)
        begin
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    o[8*(4*c+r) +: 8] = sbyte(s[8*(4*((c+r)%4)+r) +: 8]);
            s = o;
            if (rnd < 14)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = s[8*(4*c) +: 8];
                    a1 = s[8*(4*c+1) +: 8];
                    a2 = s[8*(4*c+2) +: 8];
                    a3 = s[8*(4*c+3) +: 8];
                    o[8*(4*c) +: 8]   = gmul(a0, 8'h02) ^ gmul(a1, 8'h03) ^ a2 ^ a3;
                    o[8*(4*c+1) +: 8] = a0 ^ gmul(a1, 8'h02) ^ gmul(a2, 8'h03) ^ a3;
                    o[8*(4*c+2) +: 8] = a0 ^ a1 ^ gmul(a2, 8'h02) ^ gmul(a3, 8'h03);
                    o[8*(4*c+3) +: 8] = gmul(a0, 8'h03) ^ a1 ^ a2 ^ gmul(a3, 8'h02);
                end
                s = o;
            end
            s ^= sched[rnd];
        end
        return s;
    endfunction

    // Mirror config writes, predict on each input transfer, check each output transfer.
    always @(posedge clk or negedge rst_n)
    begin
        cipher_t exp_c;
        if (!rst_n)
        begin
            key_word = '{default: '0};
            iv_word = '{default: '0};
            chain = '0;
            expected_q.delete();
            fail_count = 0;
            result_count = 0;
            pending_count = 0;
            expand_schedule();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                result_count++;
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("ERROR: unexpected result %h_%h", cipher_high, cipher_low);
                end
                else
                begin
                    exp_c = expected_q.pop_front();
                    if (exp_c.lo !== cipher_low || exp_c.hi !== cipher_high
                        || exp_c.last !== result_last)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("ERROR: result %0d expected %h_%h/%b got %h_%h/%b",
                                     result_count, exp_c.hi, exp_c.lo, exp_c.last,
                                     cipher_high, cipher_low, result_last);
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3:
                    begin
                        key_word[cfg_idx[1:0]] = cfg_data;
                        expand_schedule();
                    end
                    REG_IV_LO, REG_IV_HI:
                    begin
                        iv_word[cfg_idx[0]] = cfg_data;
                        chain = {iv_word[1], iv_word[0]};
                    end
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                chain = encrypt_block({plain_high, plain_low} ^ chain);
                exp_c.lo = chain[63:0];
                exp_c.hi = chain[127:64];
                exp_c.last = block_last;
                expected_q.push_back(exp_c);
            end
            pending_count = expected_q.size();
        end
    end

endmodule

// File: tb/sv/testbench.sv
// Top of the AES-256 CBC encryptor testbench: clock, reset, stimulus and verdict.
// Depends on aes_pkg, aes256_cbc_encrypt and aes256_cbc_checker.
`timescale 1ns / 1ps

module testbench;
    import aes_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [WORD_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [WORD_W-1:0]    plain_low;
    logic [WORD_W-1:0]    plain_high;
    logic                 block_last;
    logic                 out_valid;
    logic                 out_ready;
    logic [WORD_W-1:0]    cipher_low;
    logic [WORD_W-1:0]    cipher_high;
    logic                 result_last;
    int                   fail_count;
    int                   pending_count;
    int                   result_count;
    int                   send_idle_pct;
    int                   recv_stall_pct;
    int                   hold_off_cycles;
    int                   cycle_count;
    int                   blocks_sent;
    int                   key_writes;

    aes256_cbc_encrypt dut (.*);

    aes256_cbc_checker checker_i (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Run limit: at least 1220 blocks plus stalls, with a wide margin.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 400000)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, plus an occasional long hold-off counted here.
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Config and input drive changes at the falling edge only, so blocking
    // assignments keep back-to-back calls free of racing updates.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx <= REG_KEY3)
            key_writes++;
    endtask

    // Waits until every result is in, then lets the key schedule settle.
    task automatic drain();
        while (pending_count != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    task automatic send_block(input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi,
                              input logic last);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        in_valid = 1'b1;
        plain_low = lo;
        plain_high = hi;
        block_last = last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
        blocks_sent++;
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Message of random length; about half start by reloading the IV.
    task automatic send_message(input int len);
        if ($urandom_range(1))
        begin
            drain();
            write_reg(REG_IV_LO, rand_word());
            write_reg(REG_IV_HI, rand_word());
        end
        for (int i = 0; i < len; i++)
            send_block(rand_word(), rand_word(), i == len - 1);
    endtask

    initial
    begin
        cycle_count = 0;
        blocks_sent = 0;
        key_writes = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = REG_KEY0;
        cfg_data = '0;
        in_valid = 1'b0;
        plain_low = '0;
        plain_high = '0;
        block_last = 1'b0;
        out_ready = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        repeat (10) @(negedge clk);

        // Directed: zero key before any write, then the FIPS-197 AES-256 key.
        send_block('0, '0, 1'b0);
        send_block('1, '1, 1'b1);
        drain();
        write_reg(REG_KEY0, 64'h0706050403020100);
        write_reg(REG_KEY1, 64'h0f0e0d0c0b0a0908);
        write_reg(REG_KEY2, 64'h1716151413121110);
        write_reg(REG_KEY3, 64'h1f1e1d1c1b1a1918);
        send_block(64'h7766554433221100, 64'hffeeddccbbaa9988, 1'b1);
        send_block(64'h8000000000000001, 64'h0000000000000000, 1'b0);
        drain();
        write_reg(REG_IV_LO, '1);
        write_reg(REG_IV_HI, '1);
        send_block('1, '0, 1'b0);
        send_block('0, '1, 1'b1);
        drain();
        write_reg(REG_KEY0, '1);
        write_reg(REG_KEY1, '1);
        write_reg(REG_KEY2, '1);
        write_reg(REG_KEY3, '1);
        // Indexes past the last register are ignored.
        write_reg(REG_IV_HI + CFG_IDX_W'(1), '1);
        write_reg(REG_IV_HI + CFG_IDX_W'(2), '0);
        send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1);
        send_block('0, '0, 1'b1);

        // Long receiver hold-off while blocks keep coming, so the input stalls.
        hold_off_cycles = 200;
        for (int i = 0; i < 6; i++)
            send_block(rand_word(), rand_word(), i == 5);
        drain();

        // Random messages over four idling phases, run twice, with a new key word each phase.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            drain();
            write_reg(REG_KEY0 + CFG_IDX_W'(ph % 4), rand_word());
            while (blocks_sent < 20 + 150 * (ph + 1))
                send_message($urandom_range(1, 8));
            if (ph == 4)
                hold_off_cycles = 150;
        end

        drain();
        repeat (40) @(negedge clk);
        $display("Covered %0d blocks and %0d results across %0d key writes,",
                 blocks_sent, result_count, key_writes);
        $display("with IV reloads, back-pressure phases and long receiver hold-offs.");
        if (fail_count == 0 && pending_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
